// ----- hw/rtl/bpd_pkg.sv -----
`default_nettype none

package bpd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CFG_W       = 11;
    localparam int CFG_AW      = 1;
    localparam int ALPHA_W     = 8;
    localparam int PIX_W       = 10;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * PIX_W - 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_AW + 1;
    // queued results plus the one in the decide stage must stay below this
    localparam int FIFO_LIMIT  = FIFO_DEPTH - 1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = CFG_AW'(1);

    // one accepted transaction, as handed from the sequencer to the line stores
    typedef struct packed {
        logic             decide;
        logic             wr_pend;
        logic             opaque;
        logic             has_left;
        logic             has_right;
        logic             has_up;
        logic             has_below;
        logic             frame_end;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } bpd_op_t;

    typedef struct packed {
        logic             frame_end;
        logic             is_boundary;
        logic [PIX_W-1:0] pixel_y;
        logic [PIX_W-1:0] pixel_x;
    } bpd_res_t;

    // last valid column for a programmed width (0 reads as 1, clamp to max)
    function automatic logic [COL_W-1:0] width_last(input logic [CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_WIDTH) begin
            n = MAX_WIDTH;
        end
        return COL_W'(n - 1);
    endfunction

    function automatic logic [ROW_W-1:0] height_last(input logic [CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_HEIGHT) begin
            n = MAX_HEIGHT;
        end
        return ROW_W'(n - 1);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/alpha_boundary_pixel_detector.sv -----
// Four-neighbor boundary pixel detector.
// Input stream: alpha bytes of an image in raster order on s_tdata, with
// s_tuser selecting a pixel (0) or a drain transaction (1). A pixel is
// decided one row late, when the pixel below it arrives; after the last
// pixel of a frame, one drain transaction per column decides the last row.
// Output stream: one transaction per decided pixel with its column, row and
// boundary flag on m_tdata; m_tlast marks the final pixel of the frame.
// A result is registered in the decide stage and then in the result queue.
// Throughput: one transaction per cycle while s_tready is high; the two line
// stores are each read once and written once per cycle, with a write to the
// entry being read forwarded from the decide stage.
// A small result queue decouples the sides: s_tready drops only when the
// queue, together with the transaction in the decide stage, nears full
// because the receiver holds m_tready low.
// Reset clears the pointers and the queue and sets width and height to 1024;
// line store contents are not cleared. A register write restarts the frame.
// The user must issue it only while idle; the block does not enforce it.
`default_nettype none

module alpha_boundary_pixel_detector (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,     // alpha[7:0]
    input  wire logic                             s_tuser,     // op
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // pixel_x[9:0], pixel_y[19:10], is_boundary[20], zero[23:21]
    output logic [bpd_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tlast,     // frame_end
    input  wire logic                             cfg_wr_en,
    input  wire logic [bpd_pkg::CFG_AW-1:0]       cfg_addr,
    input  wire logic [bpd_pkg::CFG_W-1:0]        cfg_wr_data
);
    import bpd_pkg::*;

    logic                  in_accept;
    bpd_op_t               op;
    logic                  b_valid;
    logic                  res_push;
    bpd_res_t              res;
    bpd_res_t              out_res;
    logic [FIFO_CNT_W-1:0] fifo_level;
    logic [FIFO_CNT_W-1:0] in_flight;

    assign in_flight = fifo_level + FIFO_CNT_W'(b_valid);
    assign s_tready  = (in_flight < FIFO_CNT_W'(FIFO_LIMIT));
    assign in_accept = s_tvalid && s_tready;

    bpd_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .in_op       (s_tuser),
        .in_alpha    (s_tdata[ALPHA_W-1:0]),
        .op_out      (op)
    );

    bpd_line_mem u_line_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (in_accept),
        .op_in    (op),
        .b_valid  (b_valid),
        .res_push (res_push),
        .res      (res)
    );

    bpd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res),
        .level     (fifo_level)
    );

    assign m_tdata = {OUT_PAD_W'(0), out_res.is_boundary, out_res.pixel_y, out_res.pixel_x};
    assign m_tlast = out_res.frame_end;

    // a result comes only from a transaction accepted the cycle before
    a_push_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> $past(s_tvalid && s_tready))
        else $error("result pushed without an accepted transaction");

    // the ready rule must keep the result queue from overflowing
    a_fifo_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (fifo_level != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // the end-of-frame result is always produced by a drain transaction
    a_end_from_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_push && res.frame_end) |-> $past(s_tuser == OP_DRAIN))
        else $error("frame end on a pixel transaction");

endmodule

`default_nettype wire

// ----- hw/rtl/bpd_seq.sv -----
`default_nettype none

module bpd_seq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [bpd_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [bpd_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                         in_accept,
    input  wire logic                         in_op,
    input  wire logic [bpd_pkg::ALPHA_W-1:0]  in_alpha,
    output bpd_pkg::bpd_op_t                  op_out
);
    import bpd_pkg::*;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] drain_col_reg, drain_col_next;
    logic             last_row_full_reg, last_row_full_next;
    logic [COL_W-1:0] w_last_reg;
    logic [ROW_W-1:0] h_last_reg;

    logic [COL_W-1:0] px_col;
    logic [ROW_W-1:0] px_row;
    bpd_op_t          op;

    // a pixel arriving while the last row waits starts a new frame
    assign px_col = last_row_full_reg ? '0 : in_col_reg;
    assign px_row = last_row_full_reg ? '0 : in_row_reg;

    always_comb begin
        op                 = '0;
        in_col_next        = in_col_reg;
        in_row_next        = in_row_reg;
        drain_col_next     = drain_col_reg;
        last_row_full_next = last_row_full_reg;
        if (in_op == OP_DRAIN) begin
            op.col       = drain_col_reg;
            op.row       = h_last_reg;
            op.decide    = last_row_full_reg;
            op.has_left  = (drain_col_reg != '0);
            op.has_right = (drain_col_reg != w_last_reg);
            op.has_up    = (h_last_reg != '0);
            op.frame_end = (drain_col_reg == w_last_reg);
            if (last_row_full_reg) begin
                if (drain_col_reg == w_last_reg) begin
                    last_row_full_next = 1'b0;
                    drain_col_next     = '0;
                end else begin
                    drain_col_next = drain_col_reg + COL_W'(1);
                end
            end
        end else begin
            op.col       = px_col;
            op.row       = px_row - ROW_W'(1);
            op.decide    = (px_row != '0);
            op.wr_pend   = 1'b1;
            op.opaque    = (in_alpha != '0);
            op.has_left  = (px_col != '0);
            op.has_right = (px_col != w_last_reg);
            op.has_up    = (px_row > ROW_W'(1));
            op.has_below = 1'b1;
            last_row_full_next = 1'b0;
            if (px_col == w_last_reg) begin
                in_col_next = '0;
                if (px_row == h_last_reg) begin
                    in_row_next        = '0;
                    last_row_full_next = 1'b1;
                    drain_col_next     = '0;
                end else begin
                    in_row_next = px_row + ROW_W'(1);
                end
            end else begin
                in_col_next = px_col + COL_W'(1);
                in_row_next = px_row;
            end
        end
    end

    assign op_out = op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg        <= '0;
            in_row_reg        <= '0;
            drain_col_reg     <= '0;
            last_row_full_reg <= 1'b0;
            w_last_reg        <= width_last(CFG_W'(1024));
            h_last_reg        <= height_last(CFG_W'(1024));
        end else if (cfg_wr_en) begin
            // any register write restarts the frame
            if (cfg_addr == REG_IMAGE_WIDTH) begin
                w_last_reg <= width_last(cfg_wr_data);
            end
            if (cfg_addr == REG_IMAGE_HEIGHT) begin
                h_last_reg <= height_last(cfg_wr_data);
            end
            in_col_reg        <= '0;
            in_row_reg        <= '0;
            drain_col_reg     <= '0;
            last_row_full_reg <= 1'b0;
        end else if (in_accept) begin
            in_col_reg        <= in_col_next;
            in_row_reg        <= in_row_next;
            drain_col_reg     <= drain_col_next;
            last_row_full_reg <= last_row_full_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bpd_line_mem.sv -----
`default_nettype none

module bpd_line_mem (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               op_valid,
    input  wire bpd_pkg::bpd_op_t   op_in,
    output logic                    b_valid,
    output logic                    res_push,
    output bpd_pkg::bpd_res_t       res
);
    import bpd_pkg::*;

    logic pend_mem  [MAX_WIDTH];
    logic above_mem [MAX_WIDTH];

    logic [COL_W-1:0] rd_right_addr;

    bpd_op_t b_op_reg;
    logic    b_valid_reg;
    logic    right_q_reg;
    logic    up_q_reg;
    logic    fwd_right_reg, fwd_right_data_reg;
    logic    fwd_up_reg, fwd_up_data_reg;
    logic    carry_reg;
    logic    left_reg;
    logic    pend0_reg;

    logic right_bit, up_bit, self_bit, hit;
    logic pend_we, above_we;

    assign rd_right_addr = op_in.col + COL_W'(1);

    // decide stage
    assign pend_we   = b_valid_reg && b_op_reg.wr_pend;
    assign above_we  = b_valid_reg && b_op_reg.decide;
    assign right_bit = fwd_right_reg ? fwd_right_data_reg : right_q_reg;
    assign up_bit    = fwd_up_reg ? fwd_up_data_reg : up_q_reg;
    // pending bit of the pixel itself was fetched as the right neighbor last time
    assign self_bit  = (b_op_reg.col == '0) ? pend0_reg : carry_reg;

    assign hit = (b_op_reg.has_left  && !left_reg)  ||
                 (b_op_reg.has_right && !right_bit) ||
                 (b_op_reg.has_up    && !up_bit)    ||
                 (b_op_reg.has_below && !b_op_reg.opaque);

    assign b_valid         = b_valid_reg;
    assign res_push        = above_we;
    assign res.pixel_x     = PIX_W'(b_op_reg.col);
    assign res.pixel_y     = PIX_W'(b_op_reg.row);
    assign res.is_boundary = self_bit && hit;
    assign res.frame_end   = b_op_reg.frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= op_valid;
        end
    end

    // read stage: fetch and catch a write to the same entry in flight
    always_ff @(posedge aclk) begin
        b_op_reg           <= op_in;
        right_q_reg        <= pend_mem[rd_right_addr];
        up_q_reg           <= above_mem[op_in.col];
        fwd_right_reg      <= pend_we && (b_op_reg.col == rd_right_addr);
        fwd_right_data_reg <= b_op_reg.opaque;
        fwd_up_reg         <= above_we && (b_op_reg.col == op_in.col);
        fwd_up_data_reg    <= self_bit;
        if (pend_we) begin
            pend_mem[b_op_reg.col] <= b_op_reg.opaque;
        end
        if (above_we) begin
            above_mem[b_op_reg.col] <= self_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (above_we) begin
            carry_reg <= right_bit;
            left_reg  <= self_bit;
        end
        if (pend_we && (b_op_reg.col == '0)) begin
            pend0_reg <= b_op_reg.opaque;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bpd_out_fifo.sv -----
`default_nettype none

module bpd_out_fifo (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            push,
    input  wire bpd_pkg::bpd_res_t               push_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output bpd_pkg::bpd_res_t                    out_data,
    output logic [bpd_pkg::FIFO_CNT_W-1:0]       level
);
    import bpd_pkg::*;

    bpd_res_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
module tb;
    import bpd_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic [7:0]             s_tdata     = '0;      // alpha[7:0]
    logic                   s_tuser     = 1'b0;    // op
    logic                   m_tready    = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0]      cfg_addr    = '0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;               // pixel_x[9:0], pixel_y[19:10],
                                                   // is_boundary[20], zero[23:21]
    wire                    m_tlast;               // frame_end

    alpha_boundary_pixel_detector i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow of the detector: line stores, pointers and registers
    bit               above_bits [MAX_WIDTH];
    bit               pend_bits  [MAX_WIDTH];
    int               in_col;
    int               in_row;
    int               dec_col;
    bit               last_row_waiting;
    logic [CFG_W-1:0] width_reg  = CFG_W'(1024);
    logic [CFG_W-1:0] height_reg = CFG_W'(1024);

    bpd_res_t decided_pixels [$];
    bpd_res_t head_result;
    int       fail_count    = 0;
    int       live_items    = 0;
    int       cycle_count   = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int max_dim);
        if (v == 0) begin
            return 1;
        end
        if (int'(v) > max_dim) begin
            return max_dim;
        end
        return int'(v);
    endfunction

    function automatic void restart_frame();
        in_col           = 0;
        in_row           = 0;
        dec_col          = 0;
        last_row_waiting = 1'b0;
    endfunction

    // decide pending pixel dx; its bit moves into the above store
    function automatic bit classify_pixel(input int dx, input int dy, input bit has_below,
                                          input bit below_opaque, input int w);
        bit center;
        bit hit;
        center = pend_bits[dx];
        hit    = 1'b0;
        if (dx > 0 && !above_bits[dx-1]) hit = 1'b1;
        if (dx + 1 < w && !pend_bits[dx+1]) hit = 1'b1;
        if (dy > 0 && !above_bits[dx]) hit = 1'b1;
        if (has_below && !below_opaque) hit = 1'b1;
        above_bits[dx] = center;
        return center && hit;
    endfunction

    function automatic void queue_decision(input int x, input int y, input bit b, input bit fin);
        bpd_res_t r;
        r.pixel_x     = PIX_W'(x);
        r.pixel_y     = PIX_W'(y);
        r.is_boundary = b;
        r.frame_end   = fin;
        decided_pixels = {decided_pixels, r};
    endfunction

    // returns 0 when the transaction leaves the detector untouched
    function automatic bit predict_item(input logic op, input logic [7:0] a);
        int w;
        int h;
        int x;
        int y;
        bit opq;
        bit b;
        bit fin;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (op == OP_DRAIN) begin
            if (!last_row_waiting || dec_col >= w) begin
                return 1'b0;
            end
            b   = classify_pixel(dec_col, h - 1, 1'b0, 1'b0, w);
            fin = (dec_col + 1 == w);
            queue_decision(dec_col, h - 1, b, fin);
            if (fin) begin
                last_row_waiting = 1'b0;
                dec_col          = 0;
            end else begin
                dec_col++;
            end
            return 1'b1;
        end
        opq = (a != 0);
        // drop the undrained last row and start a new frame
        if (last_row_waiting) restart_frame();
        x = in_col;
        y = in_row;
        if (x >= w || y >= h) begin
            restart_frame();
            x = 0;
            y = 0;
        end
        if (y > 0) begin
            b = classify_pixel(x, y - 1, 1'b1, opq, w);
            queue_decision(x, y - 1, b, 1'b0);
            dec_col = (x + 1 == w) ? 0 : x + 1;
        end
        pend_bits[x] = opq;
        if (x + 1 == w) begin
            in_col = 0;
            if (y + 1 == h) begin
                in_row           = 0;
                last_row_waiting = 1'b1;
                dec_col          = 0;
            end else begin
                in_row = y + 1;
            end
        end else begin
            in_col = x + 1;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_alpha(input int zero_pct);
        if ($urandom_range(0, 99) < zero_pct) begin
            return 8'd0;
        end
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_item(input logic op, input logic [7:0] a);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = a;
        s_tuser  = op;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (predict_item(op, a)) live_items++;
    endtask

    task automatic send_pixels(input int n, input int zero_pct);
        repeat (n) send_item(OP_PIXEL, pick_alpha(zero_pct));
    endtask

    task automatic send_drains(input int n);
        repeat (n) send_item(OP_DRAIN, 8'($urandom));
    endtask

    // hold the input idle until every expected transaction has come out
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (decided_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = addr;
        cfg_wr_data = value;
        @(posedge aclk);
        if (addr == REG_IMAGE_WIDTH) begin
            width_reg = value;
        end else begin
            height_reg = value;
        end
        restart_frame();
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // reset size is 1024 wide: pixels inside the first row give no results
    task automatic test_reset_size();
        send_pixels(64, 50);
    endtask

    task automatic test_directed();
        logic [7:0] pattern [12];
        int         i;
        pattern = '{8'd255, 8'd0, 8'd1, 8'd128,
                    8'd255, 8'd255, 8'd255, 8'd0,
                    8'd0, 8'd255, 8'd255, 8'd255};
        set_frame(CFG_W'(4), CFG_W'(3));
        send_item(OP_DRAIN, 8'hFF);
        for (i = 0; i < 12; i++) begin
            // stray drain in the middle of the frame
            if (i == 8) send_item(OP_DRAIN, 8'h00);
            send_item(OP_PIXEL, pattern[i]);
        end
        send_drains(4);
        send_item(OP_DRAIN, 8'h5A);
    endtask

    task automatic test_frame_abort();
        set_frame(CFG_W'(3), CFG_W'(2));
        send_pixels(6, 30);
        send_drains(1);
        send_pixels(6, 30);
        send_drains(3);
        send_pixels(4, 30);
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
        send_pixels(9, 30);
        send_drains(3);
    endtask

    task automatic test_extreme_sizes();
        // width clamps to 1024: still inside the first row
        set_frame(CFG_W'(2047), CFG_W'(2047));
        send_pixels(48, 50);
        // one column, height clamps to 1024: every pixel after the first decides
        set_frame(CFG_W'(1), CFG_W'(2047));
        send_pixels(48, 50);
        send_drains(1);
        set_frame(CFG_W'(0), CFG_W'(0));
        send_item(OP_PIXEL, 8'hFF);
        send_drains(1);
        set_frame(CFG_W'(0), CFG_W'(2));
        send_pixels(2, 50);
        send_drains(2);
    endtask

    function automatic logic [CFG_W-1:0] random_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return CFG_W'($urandom_range(9, 16));
        return CFG_W'($urandom_range(1, 8));
    endfunction

    task automatic test_random_traffic(input int n);
        int start;
        int w;
        int h;
        int zero_pct;
        int i;
        start = live_items;
        while (live_items - start < n) begin
            case ($urandom_range(0, 3))
                1: write_reg(REG_IMAGE_WIDTH, random_dim());
                2: write_reg(REG_IMAGE_HEIGHT, random_dim());
                3: set_frame(random_dim(), random_dim());
                default: ;
            endcase
            w        = clamp_dim(width_reg, MAX_WIDTH);
            h        = clamp_dim(height_reg, MAX_HEIGHT);
            zero_pct = $urandom_range(0, 100);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    for (i = 0; i < w * h; i++) begin
                        if ($urandom_range(0, 19) == 0) send_item(OP_DRAIN, 8'($urandom));
                        send_item(OP_PIXEL, pick_alpha(zero_pct));
                    end
                    send_drains(w);
                end
                6: begin
                    // leave the last row partly drained
                    send_pixels(w * h, zero_pct);
                    send_drains($urandom_range(0, w - 1));
                end
                7: begin
                    send_pixels($urandom_range(1, w * h), zero_pct);
                    send_drains($urandom_range(0, 2));
                end
                8: begin
                    repeat ($urandom_range(4, 12)) begin
                        send_item(1'($urandom_range(0, 1)), 8'($urandom));
                    end
                end
                default: begin
                    send_pixels(w * h, zero_pct);
                    send_drains(w + $urandom_range(1, 3));
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (decided_pixels.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected transaction, expected none actual x=%0d y=%0d",
                         $time, m_tdata[PIX_W-1:0], m_tdata[2*PIX_W-1:PIX_W]);
            end else begin
                head_result = decided_pixels.pop_front();
                check_field("pixel_x", 32'(head_result.pixel_x), 32'(m_tdata[PIX_W-1:0]));
                check_field("pixel_y", 32'(head_result.pixel_y),
                            32'(m_tdata[2*PIX_W-1:PIX_W]));
                check_field("is_boundary", 32'(head_result.is_boundary),
                            32'(m_tdata[2*PIX_W]));
                check_field("frame_end", 32'(head_result.frame_end), 32'(m_tlast));
                check_field("tdata padding", 32'd0,
                            32'(m_tdata[OUT_TDATA_W-1:2*PIX_W+1]));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        restart_frame();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 48;
        test_reset_size();
        test_directed();
        test_frame_abort();
        test_extreme_sizes();
        test_random_traffic(120);

        send_idle_pct = 48;
        recv_idle_pct = 16;
        test_random_traffic(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(120);

        settle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
